[rtl/ssd_pkg.sv]
package ssd_pkg;

  localparam int WinLen    = 18;
  localparam int HeldWidth = 5;
  localparam int FifoDepth = 4;

  localparam logic [7:0] HdrByte   = 8'd19;
  localparam logic [7:0] LenByte   = 8'd15;
  localparam logic [7:0] IdCliffL  = 8'd28;
  localparam logic [7:0] IdCliffFl = 8'd29;
  localparam logic [7:0] IdCliffFr = 8'd30;
  localparam logic [7:0] IdCliffR  = 8'd31;
  localparam logic [7:0] IdDist    = 8'd19;

  typedef enum logic {
    STAT_VALID     = 1'b0,
    STAT_MISALIGN  = 1'b1
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [15:0]        cliff_left;
    logic [15:0]        cliff_front_left;
    logic [15:0]        cliff_front_right;
    logic [15:0]        cliff_right;
    logic signed [15:0] wheel_distance;
  } frame_res_t;

  localparam int ResWidth = $bits(frame_res_t);

endpackage

[rtl/ssd_front.sv]
module ssd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic [7:0]        in_rx_byte,
  output logic              res_push,
  output ssd_pkg::frame_res_t res_word
);
  import ssd_pkg::*;

  logic [7:0]           hist_r [WinLen-1];
  logic [HeldWidth-1:0] held_r, held_nxt;
  logic [HeldWidth-1:0] held_eff;
  logic [7:0]           win [WinLen];
  logic [7:0]           s1 [9];
  logic [7:0]           s2 [5];
  logic [7:0]           s3 [2];
  logic [7:0]           sum;
  logic                 hdr_ok;
  logic                 frame_ok;
  logic                 win_full;

  always_comb begin
    for (int i = 0; i < WinLen - 1; i++) begin
      win[i] = hist_r[i];
    end
    win[WinLen-1] = in_rx_byte;
  end

  // byte sum mod 256 as a tree
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      s1[i] = win[2*i] + win[2*i+1];
    end
    for (int i = 0; i < 4; i++) begin
      s2[i] = s1[2*i] + s1[2*i+1];
    end
    s2[4] = s1[8];
    s3[0] = s2[0] + s2[1];
    s3[1] = s2[2] + s2[3];
    sum   = s3[0] + s3[1] + s2[4];
  end

  assign hdr_ok = (win[0] == HdrByte) && (win[1] == LenByte) &&
                  (win[2] == IdCliffL) && (win[5] == IdCliffFl) &&
                  (win[8] == IdCliffFr) && (win[11] == IdCliffR) &&
                  (win[14] == IdDist);
  assign frame_ok = hdr_ok && (sum == 8'd0);

  assign held_eff = (held_r >= HeldWidth'(WinLen)) ? '0 : held_r;
  assign win_full = (held_eff == HeldWidth'(WinLen - 1));

  always_comb begin
    held_nxt = held_r;
    if (in_accept) begin
      if (!win_full) begin
        held_nxt = held_eff + 1'b1;
      end else if (frame_ok) begin
        held_nxt = '0;
      end else begin
        held_nxt = HeldWidth'(WinLen - 1);
      end
    end
  end

  assign res_push = in_accept && win_full;

  always_comb begin
    res_word.status            = frame_ok ? STAT_VALID : STAT_MISALIGN;
    res_word.cliff_left        = {win[3], win[4]};
    res_word.cliff_front_left  = {win[6], win[7]};
    res_word.cliff_front_right = {win[9], win[10]};
    res_word.cliff_right       = {win[12], win[13]};
    res_word.wheel_distance    = {win[15], win[16]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  // history of the last bytes; oldest at index 0
  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < WinLen - 2; i++) begin
        hist_r[i] <= hist_r[i+1];
      end
      hist_r[WinLen-2] <= in_rx_byte;
    end
  end

endmodule

[rtl/ssd_fifo.sv]
module ssd_fifo #(
  parameter int DEPTH = ssd_pkg::FifoDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  ssd_pkg::frame_res_t wr_word,
  output logic               q_full,
  input  logic               rd_en,
  output ssd_pkg::frame_res_t rd_word,
  output logic               q_empty
);
  import ssd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frame_res_t      mem_r [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW-1:0]   rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign q_full  = (cnt_r == CW'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_word = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (rd_en) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_word;
    end
  end

endmodule

[rtl/ssd_back.sv]
module ssd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  ssd_pkg::frame_res_t q_word,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output ssd_pkg::frame_res_t out_word
);
  import ssd_pkg::*;

  logic       vld_r, vld_nxt;
  frame_res_t word_r;
  frame_res_t word_nxt;

  assign q_pop = !q_empty && (!vld_r || pop);
  assign empty = !vld_r;
  assign out_word = word_r;

  always_comb begin
    vld_nxt = vld_r;
    if (q_pop) begin
      vld_nxt = 1'b1;
    end else if (pop) begin
      vld_nxt = 1'b0;
    end
  end

  // misaligned frames report zero readings
  always_comb begin
    word_nxt = q_word;
    if (q_word.status == STAT_MISALIGN) begin
      word_nxt.cliff_left        = '0;
      word_nxt.cliff_front_left  = '0;
      word_nxt.cliff_front_right = '0;
      word_nxt.cliff_right       = '0;
      word_nxt.wheel_distance    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      word_r <= word_nxt;
    end
  end

endmodule

[rtl/sensor_stream_packet_deframer_unit.sv]
// Sensor stream deframer: takes one received byte per word on the push/full
// side, one per clock cycle while full is low, and slides it into an 18-byte frame window.
// Whenever the window fills, header, length, sensor identifier bytes and the
// byte sum are checked in the same cycle; a good frame yields one result word
// with four cliff readings and the signed wheel distance and empties the
// window, a bad frame yields a misaligned word with zero readings and drops
// only the oldest byte. Results wait in a FIFO_DEPTH-entry queue plus one
// output register; full rises only when that queue is full and the result
// side has not taken words, so with a draining consumer every byte is taken
// in the cycle it is offered, and a result passes through the queue into the
// output register after its last byte. No clearing pass after reset.
module sensor_stream_packet_deframer_unit #(
  parameter int FIFO_DEPTH = ssd_pkg::FifoDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_rx_byte,
  input  logic               pop,
  output logic               empty,
  output logic               out_status,
  output logic [15:0]        out_cliff_left,
  output logic [15:0]        out_cliff_front_left,
  output logic [15:0]        out_cliff_front_right,
  output logic [15:0]        out_cliff_right,
  output logic signed [15:0] out_wheel_distance
);
  import ssd_pkg::*;

  logic       in_accept;
  logic       res_push;
  frame_res_t res_word;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  frame_res_t q_word;
  frame_res_t out_word;

  assign full      = q_full;
  assign in_accept = push && !q_full;

  ssd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_rx_byte (in_rx_byte),
    .res_push   (res_push),
    .res_word   (res_word)
  );

  ssd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_word (res_word),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_word (q_word),
    .q_empty (q_empty)
  );

  ssd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_word   (q_word),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_word (out_word)
  );

  assign out_status            = out_word.status;
  assign out_cliff_left        = out_word.cliff_left;
  assign out_cliff_front_left  = out_word.cliff_front_left;
  assign out_cliff_front_right = out_word.cliff_front_right;
  assign out_cliff_right       = out_word.cliff_right;
  assign out_wheel_distance    = out_word.wheel_distance;

endmodule

[tb/ssd_frame_checker.sv]
`timescale 1ns / 1ps
module ssd_frame_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  logic [7:0]         in_rx_byte,
  input  logic               pop,
  input  logic               empty,
  input  logic               out_status,
  input  logic [15:0]        out_cliff_left,
  input  logic [15:0]        out_cliff_front_left,
  input  logic [15:0]        out_cliff_front_right,
  input  logic [15:0]        out_cliff_right,
  input  logic signed [15:0] out_wheel_distance,
  output int                 mismatch_count,
  output int                 frames_pending
);
  import ssd_pkg::*;

  logic [7:0]           win [WinLen];
  logic [HeldWidth-1:0] held;
  frame_res_t           expected_frames [$];

  function automatic logic window_good();
    logic [7:0] sum;
    sum = 8'd0;
    if (win[0] != HdrByte || win[1] != LenByte || win[2] != IdCliffL ||
        win[5] != IdCliffFl || win[8] != IdCliffFr || win[11] != IdCliffR ||
        win[14] != IdDist)
      return 1'b0;
    for (int i = 0; i < WinLen; i++)
      sum += win[i];
    return sum == 8'd0;
  endfunction

  task automatic slide_in_byte(input logic [7:0] b);
    frame_res_t res;
    if (held >= WinLen)
      held = '0;
    win[held] = b;
    held++;
    if (held == WinLen) begin
      if (window_good()) begin
        res.status            = STAT_VALID;
        res.cliff_left        = {win[3], win[4]};
        res.cliff_front_left  = {win[6], win[7]};
        res.cliff_front_right = {win[9], win[10]};
        res.cliff_right       = {win[12], win[13]};
        res.wheel_distance    = {win[15], win[16]};
        held = '0;
      end else begin
        res = '0;
        res.status = STAT_MISALIGN;
        for (int i = 0; i < WinLen - 1; i++)
          win[i] = win[i + 1];
        held = HeldWidth'(WinLen - 1);
      end
      expected_frames.push_back(res);
    end
  endtask

  task automatic check_result_word();
    frame_res_t want;
    frame_res_t got;
    got.status            = status_t'(out_status);
    got.cliff_left        = out_cliff_left;
    got.cliff_front_left  = out_cliff_front_left;
    got.cliff_front_right = out_cliff_front_right;
    got.cliff_right       = out_cliff_right;
    got.wheel_distance    = out_wheel_distance;
    if (expected_frames.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result word st=%b cl=%h cfl=%h cfr=%h cr=%h wd=%h",
                 $realtime, got.status, got.cliff_left, got.cliff_front_left,
                 got.cliff_front_right, got.cliff_right, got.wheel_distance);
    end else begin
      want = expected_frames.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: mismatch exp st=%b cl=%h cfl=%h cfr=%h cr=%h wd=%h",
                   $realtime, want.status, want.cliff_left, want.cliff_front_left,
                   want.cliff_front_right, want.cliff_right, want.wheel_distance);
          $display("%0t:          got st=%b cl=%h cfl=%h cfr=%h cr=%h wd=%h",
                   $realtime, got.status, got.cliff_left, got.cliff_front_left,
                   got.cliff_front_right, got.cliff_right, got.wheel_distance);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held = '0;
      expected_frames.delete();
      mismatch_count = 0;
    end else begin
      if (pop && !empty)
        check_result_word();
      if (push && !full)
        slide_in_byte(in_rx_byte);
    end
    frames_pending = expected_frames.size();
  end

endmodule

[tb/tb_sensor_stream_packet_deframer_unit.sv]
`timescale 1ns / 1ps
module tb_sensor_stream_packet_deframer_unit;
  import ssd_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  logic [7:0]         in_rx_byte;
  logic               pop;
  logic               empty;
  logic               out_status;
  logic [15:0]        out_cliff_left;
  logic [15:0]        out_cliff_front_left;
  logic [15:0]        out_cliff_front_right;
  logic [15:0]        out_cliff_right;
  logic signed [15:0] out_wheel_distance;

  int mismatch_count;
  int frames_pending;
  int idle_pct;
  int stall_pct;
  int bytes_sent;
  bit hold_req;

  sensor_stream_packet_deframer_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_rx_byte           (in_rx_byte),
    .pop                  (pop),
    .empty                (empty),
    .out_status           (out_status),
    .out_cliff_left       (out_cliff_left),
    .out_cliff_front_left (out_cliff_front_left),
    .out_cliff_front_right(out_cliff_front_right),
    .out_cliff_right      (out_cliff_right),
    .out_wheel_distance   (out_wheel_distance)
  );

  ssd_frame_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_rx_byte           (in_rx_byte),
    .pop                  (pop),
    .empty                (empty),
    .out_status           (out_status),
    .out_cliff_left       (out_cliff_left),
    .out_cliff_front_left (out_cliff_front_left),
    .out_cliff_front_right(out_cliff_front_right),
    .out_cliff_right      (out_cliff_right),
    .out_wheel_distance   (out_wheel_distance),
    .mismatch_count       (mismatch_count),
    .frames_pending       (frames_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stalls plus a long hold-off on request
  initial begin
    int hold_left;
    pop = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = 100;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    push <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      in_rx_byte <= 8'($urandom);
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [79:0] rd, input bit corrupt);
    logic [7:0] fr [WinLen];
    logic [7:0] sum;
    int k;
    fr[0]  = HdrByte;
    fr[1]  = LenByte;
    fr[2]  = IdCliffL;
    fr[3]  = rd[79:72];
    fr[4]  = rd[71:64];
    fr[5]  = IdCliffFl;
    fr[6]  = rd[63:56];
    fr[7]  = rd[55:48];
    fr[8]  = IdCliffFr;
    fr[9]  = rd[47:40];
    fr[10] = rd[39:32];
    fr[11] = IdCliffR;
    fr[12] = rd[31:24];
    fr[13] = rd[23:16];
    fr[14] = IdDist;
    fr[15] = rd[15:8];
    fr[16] = rd[7:0];
    sum = 8'd0;
    for (int i = 0; i < WinLen - 1; i++)
      sum += fr[i];
    fr[WinLen - 1] = 8'd0 - sum;
    if (corrupt) begin
      k = $urandom_range(WinLen - 1);
      fr[k] = fr[k] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < WinLen; i++)
      send_byte(fr[i]);
  endtask

  initial begin
    logic [79:0] rd;
    rst_n = 1'b0;
    push = 1'b0;
    in_rx_byte = 8'd0;
    idle_pct = 0;
    stall_pct = 0;
    bytes_sent = 0;
    hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // good frame with extreme readings, then a partial window of stray bytes
    send_frame({16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000}, 1'b0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HdrByte);
    send_byte(LenByte);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h01);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      if (ph == 0) begin
        // receiver holds off while misaligned words pile up
        hold_req = 1'b1;
        repeat (40) send_byte(8'($urandom));
      end
      while (bytes_sent < 25 + (ph + 1) * 275) begin
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        for (int j = 0; j < 10; j++) begin
          case ($urandom_range(9))
            0: rd[j*8 +: 8] = 8'h00;
            1: rd[j*8 +: 8] = 8'hFF;
            default: rd[j*8 +: 8] = 8'($urandom);
          endcase
        end
        send_frame(rd, $urandom_range(3) == 0);
      end
    end
    push <= 1'b0;
    @(posedge clk);

    while (frames_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && frames_pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
